// ===== hdl/kdeg_pkg.sv =====
// ============================================================================
// kdeg_pkg: shared types and constants for the key debounce event generator
// Event kinds, per-key config and event bundles, register map, reset values.
// ============================================================================
package kdeg_pkg;

    localparam int NUM_KEYS  = 3;
    localparam int NUM_SLOTS = 2 * NUM_KEYS;

    // Event kinds as they appear on the output
    typedef enum logic [1:0] {
        EV_DOWN = 2'd0,
        EV_UP   = 2'd1,
        EV_LONG = 2'd2
    } ev_kind_t;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_FILTER_TIME   = 3'd0;
    localparam logic [2:0] REG_LONG_KEY0     = 3'd1;
    localparam logic [2:0] REG_LONG_KEY1     = 3'd2;
    localparam logic [2:0] REG_LONG_COMBO    = 3'd3;
    localparam logic [2:0] REG_REPEAT_KEY0   = 3'd4;
    localparam logic [2:0] REG_REPEAT_KEY1   = 3'd5;
    localparam logic [2:0] REG_REPEAT_COMBO  = 3'd6;

    // Reset values
    localparam logic [6:0]  RST_FILTER_TIME  = 7'd5;
    localparam logic [15:0] RST_LONG_TIME    = 16'd100;
    localparam logic [7:0]  RST_REPEAT_KEY0  = 8'd5;
    localparam logic [7:0]  RST_REPEAT_KEY1  = 8'd6;
    localparam logic [7:0]  RST_REPEAT_COMBO = 8'd5;
    localparam logic [7:0]  RST_COUNT        = 8'(RST_FILTER_TIME / 2);

    // Per-key settings
    typedef struct packed {
        logic [6:0]  filter_time;
        logic [15:0] long_time;
        logic [7:0]  repeat_speed;
    } key_cfg_t;

    // Events of one key for one tick: primary (down/up), secondary (long/repeat)
    typedef struct packed {
        logic     pri_vld;
        ev_kind_t pri_kind;
        logic     sec_vld;
        ev_kind_t sec_kind;
    } key_ev_t;

endpackage

// ===== hdl/kdeg_ifs.sv =====
// ============================================================================
// kdeg_ifs: valid/ready channels of the key debounce event generator
// One interface for button ticks, one for events.
// ============================================================================
interface kdeg_key_if;
    logic valid;
    logic ready;
    logic button0_level;
    logic button1_level;

    modport source (output valid, output button0_level, output button1_level,
                    input ready);
    modport sink   (input valid, input button0_level, input button1_level,
                    output ready);
endinterface

interface kdeg_event_if;
    logic       valid;
    logic       ready;
    logic [3:0] event_code;
    logic [1:0] key_number;
    logic [1:0] event_kind;
    logic       last_event;

    modport source (output valid, output event_code, output key_number,
                    output event_kind, output last_event, input ready);
    modport sink   (input valid, input event_code, input key_number,
                    input event_kind, input last_event, output ready);
endinterface

// ===== hdl/kdeg_key_unit.sv =====
// ============================================================================
// kdeg_key_unit: debounce, long press and auto-repeat for one logical key
// Events for the current tick are combinational; state moves on step.
// ============================================================================
module kdeg_key_unit
    import kdeg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  key_cfg_t cfg,
    input  logic     clear_repeat,
    input  logic     step,
    input  logic     down,
    output key_ev_t  ev
);

    logic [7:0]  cnt_reg, cnt_next;
    logic        pressed_reg, pressed_next;
    logic [15:0] hold_reg, hold_next;
    logic [7:0]  rep_reg, rep_next;

    logic [7:0]  filt;
    logic [7:0]  two_filt;
    logic [15:0] hold_inc;
    logic [7:0]  rep_inc;

    assign filt     = {1'b0, cfg.filter_time};
    assign two_filt = {cfg.filter_time, 1'b0};
    assign hold_inc = hold_reg + 16'd1;
    assign rep_inc  = rep_reg + 8'd1;

    always_comb
    begin
        cnt_next     = cnt_reg;
        pressed_next = pressed_reg;
        hold_next    = hold_reg;
        rep_next     = rep_reg;
        ev           = '{pri_vld: 1'b0, pri_kind: EV_DOWN, sec_vld: 1'b0, sec_kind: EV_DOWN};

        if (down)
        begin
            if (cnt_reg < filt)
            begin
                cnt_next = filt;
            end
            else if (cnt_reg < two_filt)
            begin
                cnt_next = cnt_reg + 8'd1;
            end
            else
            begin
                // settled pressed
                if (!pressed_reg)
                begin
                    pressed_next = 1'b1;
                    ev.pri_vld   = 1'b1;
                    ev.pri_kind  = EV_DOWN;
                end
                if (cfg.long_time != 16'd0)
                begin
                    if (hold_reg < cfg.long_time)
                    begin
                        hold_next = hold_inc;
                        if (hold_inc == cfg.long_time)
                        begin
                            ev.sec_vld  = 1'b1;
                            ev.sec_kind = EV_LONG;
                        end
                    end
                    else if (cfg.repeat_speed != 8'd0)
                    begin
                        if (rep_inc >= cfg.repeat_speed)
                        begin
                            rep_next    = 8'd0;
                            ev.sec_vld  = 1'b1;
                            ev.sec_kind = EV_DOWN;
                        end
                        else
                        begin
                            rep_next = rep_inc;
                        end
                    end
                end
            end
        end
        else
        begin
            if (cnt_reg > filt)
            begin
                cnt_next = filt;
            end
            else if (cnt_reg != 8'd0)
            begin
                cnt_next = cnt_reg - 8'd1;
            end
            else if (pressed_reg)
            begin
                pressed_next = 1'b0;
                ev.pri_vld   = 1'b1;
                ev.pri_kind  = EV_UP;
            end
            hold_next = 16'd0;
            rep_next  = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= RST_COUNT;
            pressed_reg <= 1'b0;
            hold_reg    <= 16'd0;
            rep_reg     <= 8'd0;
        end
        else if (step)
        begin
            cnt_reg     <= cnt_next;
            pressed_reg <= pressed_next;
            hold_reg    <= hold_next;
            rep_reg     <= rep_next;
        end
        else if (clear_repeat)
        begin
            rep_reg <= 8'd0;
        end
    end

    // A tick with the key not down always clears hold and repeat
    a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && !down |=> hold_reg == 16'd0 && rep_reg == 8'd0)
        else $error("hold/repeat not cleared on release tick");

    // A down event marks the key pressed, an up event released
    a_down_sets_pressed: assert property (@(posedge clk) disable iff (!rst_n)
        step && ev.pri_vld && ev.pri_kind == EV_DOWN |=> pressed_reg)
        else $error("down event without pressed flag");

    a_up_clears_pressed: assert property (@(posedge clk) disable iff (!rst_n)
        step && ev.pri_vld && ev.pri_kind == EV_UP |=> !pressed_reg)
        else $error("up event with pressed flag still set");

endmodule

// ===== hdl/key_debounce_event_generator.sv =====
// ============================================================================
// key_debounce_event_generator: debounced two-button keypad event source
// Three logical keys (button 0 alone, button 1 alone, both) with debounce,
// long press and auto-repeat; events leave one per cycle in key order while ev_out is ready.
// ============================================================================
//
//  channel   dir  handshake        payload
//  -------   ---  ---------------  --------------------------------------------
//  key_in    in   valid/ready      button0_level, button1_level (one scan tick)
//  ev_out    out  valid/ready      event_code, key_number, event_kind, last_event
//  apb       in   psel/penable     7 registers at 4*index, pready tied high
//
//  A tick is registered on accept, evaluated combinationally by the three key
//  units, and its events (up to four) go into a bundle register. The bundle
//  drains into the output register at one event per cycle while the output
//  is not stalled; an empty tick leaves the bundle free for the next tick.
//  A new tick is taken while the last event of the previous one waits.
//  Reset is asynchronous, active low; config registers return to kdeg_pkg values.
//  Output stalls back up through the bundle to key_in.ready.
//
module key_debounce_event_generator
    import kdeg_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    kdeg_key_if.sink            key_in,
    kdeg_event_if.source        ev_out,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [6:0]  filter_time_reg;
    logic [15:0] long_time_reg [NUM_KEYS];
    logic [7:0]  repeat_speed_reg [NUM_KEYS];

    logic        cfg_wr;
    logic [2:0]  cfg_idx;
    logic [NUM_KEYS-1:0] clear_repeat;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_time_reg     <= RST_FILTER_TIME;
            long_time_reg[0]    <= RST_LONG_TIME;
            long_time_reg[1]    <= RST_LONG_TIME;
            long_time_reg[2]    <= RST_LONG_TIME;
            repeat_speed_reg[0] <= RST_REPEAT_KEY0;
            repeat_speed_reg[1] <= RST_REPEAT_KEY1;
            repeat_speed_reg[2] <= RST_REPEAT_COMBO;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_FILTER_TIME:  filter_time_reg     <= pwdata[6:0];
                REG_LONG_KEY0:    long_time_reg[0]    <= pwdata[15:0];
                REG_LONG_KEY1:    long_time_reg[1]    <= pwdata[15:0];
                REG_LONG_COMBO:   long_time_reg[2]    <= pwdata[15:0];
                REG_REPEAT_KEY0:  repeat_speed_reg[0] <= pwdata[7:0];
                REG_REPEAT_KEY1:  repeat_speed_reg[1] <= pwdata[7:0];
                REG_REPEAT_COMBO: repeat_speed_reg[2] <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Writing a key's long or repeat setting restarts its repeat count, unless a tick steps the keys in the same cycle
    always_comb
    begin
        clear_repeat = '0;
        if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_LONG_KEY0, REG_REPEAT_KEY0:   clear_repeat[0] = 1'b1;
                REG_LONG_KEY1, REG_REPEAT_KEY1:   clear_repeat[1] = 1'b1;
                REG_LONG_COMBO, REG_REPEAT_COMBO: clear_repeat[2] = 1'b1;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_FILTER_TIME:  prdata = {25'd0, filter_time_reg};
            REG_LONG_KEY0:    prdata = {16'd0, long_time_reg[0]};
            REG_LONG_KEY1:    prdata = {16'd0, long_time_reg[1]};
            REG_LONG_COMBO:   prdata = {16'd0, long_time_reg[2]};
            REG_REPEAT_KEY0:  prdata = {24'd0, repeat_speed_reg[0]};
            REG_REPEAT_KEY1:  prdata = {24'd0, repeat_speed_reg[1]};
            REG_REPEAT_COMBO: prdata = {24'd0, repeat_speed_reg[2]};
            default:          prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic in_vld_reg, in_vld_next;
    logic b0_reg, b1_reg;
    logic in_acc;
    logic tick_go;      // registered tick is evaluated and handed to the bundle

    assign key_in.ready = !in_vld_reg || tick_go;
    assign in_acc       = key_in.valid && key_in.ready;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_acc)
            in_vld_next = 1'b1;
        else if (tick_go)
            in_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= in_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            b0_reg <= key_in.button0_level;
            b1_reg <= key_in.button1_level;
        end
    end

    // ------------------------------------------------------------------
    // Key units
    // ------------------------------------------------------------------
    logic [NUM_KEYS-1:0] key_down;
    key_ev_t             key_ev [NUM_KEYS];

    assign key_down[0] = b0_reg && !b1_reg;
    assign key_down[1] = b1_reg && !b0_reg;
    assign key_down[2] = b0_reg && b1_reg;

    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_key
        key_cfg_t kcfg;

        assign kcfg.filter_time  = filter_time_reg;
        assign kcfg.long_time    = long_time_reg[k];
        assign kcfg.repeat_speed = repeat_speed_reg[k];

        kdeg_key_unit u_key (
            .clk          (clk),
            .rst_n        (rst_n),
            .cfg          (kcfg),
            .clear_repeat (clear_repeat[k]),
            .step         (tick_go),
            .down         (key_down[k]),
            .ev           (key_ev[k])
        );
    end

    // ------------------------------------------------------------------
    // Event bundle: slot 2k = key k down/up, slot 2k+1 = key k long/repeat
    // ------------------------------------------------------------------
    logic [NUM_SLOTS-1:0] bnd_mask_reg, bnd_mask_next;
    ev_kind_t             bnd_kind_reg [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] new_mask;
    logic [NUM_SLOTS-1:0] mask_after;
    logic [2:0]           pop_idx;
    logic                 pop;
    logic                 pop_last;
    logic                 bnd_free;
    logic                 out_free;

    always_comb
    begin
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            new_mask[2*k]   = key_ev[k].pri_vld;
            new_mask[2*k+1] = key_ev[k].sec_vld;
        end
    end

    // lowest pending slot goes first: key order, down/up before long/repeat
    always_comb
    begin
        logic found;
        found   = 1'b0;
        pop_idx = 3'd0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (bnd_mask_reg[i] && !found)
            begin
                pop_idx = 3'(i);
                found   = 1'b1;
            end
        end
    end

    assign mask_after = bnd_mask_reg & ~(NUM_SLOTS'(1) << pop_idx);
    assign pop_last   = (mask_after == '0);
    assign out_free   = !ev_out.valid || ev_out.ready;
    assign pop        = (bnd_mask_reg != '0) && out_free;
    assign bnd_free   = (bnd_mask_reg == '0) || (pop && pop_last);
    assign tick_go    = in_vld_reg && bnd_free;

    always_comb
    begin
        bnd_mask_next = bnd_mask_reg;
        if (tick_go)
            bnd_mask_next = new_mask;
        else if (pop)
            bnd_mask_next = mask_after;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bnd_mask_reg <= '0;
        else
            bnd_mask_reg <= bnd_mask_next;
    end

    always_ff @(posedge clk)
    begin
        if (tick_go)
        begin
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                bnd_kind_reg[2*k]   <= key_ev[k].pri_kind;
                bnd_kind_reg[2*k+1] <= key_ev[k].sec_kind;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic       out_vld_reg, out_vld_next;
    logic [3:0] out_code_reg;
    logic [1:0] out_key_reg;
    ev_kind_t   out_kind_reg;
    logic       out_last_reg;
    logic [1:0] pop_key;
    ev_kind_t   pop_kind;
    logic [3:0] pop_code;

    assign pop_key  = pop_idx[2:1];
    assign pop_kind = bnd_kind_reg[pop_idx];
    // code = 3*key + kind + 1
    assign pop_code = ({2'b00, pop_key} << 1) + {2'b00, pop_key}
                    + {2'b00, pop_kind} + 4'd1;

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (pop)
            out_vld_next = 1'b1;
        else if (ev_out.ready)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else
            out_vld_reg <= out_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_code_reg <= pop_code;
            out_key_reg  <= pop_key;
            out_kind_reg <= pop_kind;
            out_last_reg <= pop_last;
        end
    end

    assign ev_out.valid      = out_vld_reg;
    assign ev_out.event_code = out_code_reg;
    assign ev_out.key_number = out_key_reg;
    assign ev_out.event_kind = out_kind_reg;
    assign ev_out.last_event = out_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_pop_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> out_vld_reg)
        else $error("popped event did not reach output register");

    a_bundle_kept: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !pop_last |=> bnd_mask_reg != '0)
        else $error("pending events of a tick were dropped");

    a_last_marked: assert property (@(posedge clk) disable iff (!rst_n)
        pop && pop_last |=> out_last_reg)
        else $error("final event of tick not marked last");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        tick_go && bnd_mask_reg != '0 |-> pop && pop_last)
        else $error("bundle overwritten before drained");

endmodule

// ===== sim/kdeg_event_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// kdeg_event_checker: event predictor and scoreboard for the key debouncer
// Mirrors register writes from the APB port, predicts the events of every
// accepted scan tick and compares each accepted event with the oldest one.
// ============================================================================
module kdeg_event_checker
    import kdeg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    kdeg_key_if         key_mon,
    kdeg_event_if       ev_mon,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output int          mismatch_count,
    output int          events_outstanding
);

    typedef struct packed {
        logic [3:0] code;
        logic [1:0] key;
        ev_kind_t   kind;
        logic       is_last;
    } key_event_t;

    key_event_t expected_events[$];
    key_event_t tick_events[$];

    // mirrored settings
    logic [6:0]  filt;
    logic [15:0] hold_limit [NUM_KEYS];
    logic [7:0]  rep_period [NUM_KEYS];

    // mirrored per-key state
    logic [7:0]  deb_cnt  [NUM_KEYS];
    logic        pressed  [NUM_KEYS];
    logic [15:0] hold_cnt [NUM_KEYS];
    logic [7:0]  rep_cnt  [NUM_KEYS];

    int errors;

    task automatic note_event(input int k, input ev_kind_t kind);
        key_event_t e;
        e.code    = 4'(3 * k + int'(kind) + 1);
        e.key     = 2'(k);
        e.kind    = kind;
        e.is_last = 1'b0;
        tick_events.push_back(e);
    endtask

    task automatic scan_key(input int k, input bit down);
        int f;
        int c;
        int r;
        f = int'(filt);
        c = int'(deb_cnt[k]);
        if (down) begin
            if (c < f)
                deb_cnt[k] = 8'(f);
            else if (c < 2 * f)
                deb_cnt[k] = 8'(c + 1);
            else begin
                if (!pressed[k]) begin
                    pressed[k] = 1'b1;
                    note_event(k, EV_DOWN);
                end
                if (hold_limit[k] != 16'd0) begin
                    if (hold_cnt[k] < hold_limit[k]) begin
                        hold_cnt[k] = hold_cnt[k] + 16'd1;
                        if (hold_cnt[k] == hold_limit[k])
                            note_event(k, EV_LONG);
                    end else if (rep_period[k] != 8'd0) begin
                        r = (int'(rep_cnt[k]) + 1) & 255;
                        if (r >= int'(rep_period[k])) begin
                            rep_cnt[k] = 8'd0;
                            note_event(k, EV_DOWN);
                        end else
                            rep_cnt[k] = 8'(r);
                    end
                end
            end
        end else begin
            if (c > f)
                deb_cnt[k] = 8'(f);
            else if (c != 0)
                deb_cnt[k] = 8'(c - 1);
            else if (pressed[k]) begin
                pressed[k] = 1'b0;
                note_event(k, EV_UP);
            end
            hold_cnt[k] = 16'd0;
            rep_cnt[k]  = 8'd0;
        end
    endtask

    task automatic predict_tick(input logic b0, input logic b1);
        tick_events.delete();
        scan_key(0, b0 && !b1);
        scan_key(1, b1 && !b0);
        scan_key(2, b0 && b1);
        if (tick_events.size() > 0)
            tick_events[tick_events.size() - 1].is_last = 1'b1;
        foreach (tick_events[i])
            expected_events.push_back(tick_events[i]);
    endtask

    task automatic mirror_write(input logic [2:0] idx, input logic [31:0] val);
        case (idx)
            REG_FILTER_TIME:  filt = val[6:0];
            REG_LONG_KEY0:    begin hold_limit[0] = val[15:0]; rep_cnt[0] = 8'd0; end
            REG_LONG_KEY1:    begin hold_limit[1] = val[15:0]; rep_cnt[1] = 8'd0; end
            REG_LONG_COMBO:   begin hold_limit[2] = val[15:0]; rep_cnt[2] = 8'd0; end
            REG_REPEAT_KEY0:  begin rep_period[0] = val[7:0]; rep_cnt[0] = 8'd0; end
            REG_REPEAT_KEY1:  begin rep_period[1] = val[7:0]; rep_cnt[1] = 8'd0; end
            REG_REPEAT_COMBO: begin rep_period[2] = val[7:0]; rep_cnt[2] = 8'd0; end
            default: ;
        endcase
    endtask

    task automatic check_event();
        key_event_t e;
        if (expected_events.size() == 0) begin
            $error("event code %0d with nothing expected", ev_mon.event_code);
            errors++;
            return;
        end
        e = expected_events.pop_front();
        if (ev_mon.event_code !== e.code) begin
            $error("event_code: expected %0d actual %0d", e.code, ev_mon.event_code);
            errors++;
        end
        if (ev_mon.key_number !== e.key) begin
            $error("key_number: expected %0d actual %0d", e.key, ev_mon.key_number);
            errors++;
        end
        if (ev_mon.event_kind !== 2'(e.kind)) begin
            $error("event_kind: expected %0d actual %0d", e.kind, ev_mon.event_kind);
            errors++;
        end
        if (ev_mon.last_event !== e.is_last) begin
            $error("last_event: expected %0d actual %0d", e.is_last, ev_mon.last_event);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            filt = RST_FILTER_TIME;
            for (int k = 0; k < NUM_KEYS; k++) begin
                hold_limit[k] = RST_LONG_TIME;
                deb_cnt[k]    = RST_COUNT;
                pressed[k]    = 1'b0;
                hold_cnt[k]   = 16'd0;
                rep_cnt[k]    = 8'd0;
            end
            rep_period[0] = RST_REPEAT_KEY0;
            rep_period[1] = RST_REPEAT_KEY1;
            rep_period[2] = RST_REPEAT_COMBO;
            expected_events.delete();
            errors = 0;
            mismatch_count     <= 0;
            events_outstanding <= 0;
        end else begin
            if (psel && penable && pwrite && pready)
                mirror_write(paddr[4:2], pwdata);
            // compare before predicting: an event never belongs to the tick
            // accepted at the same edge
            if (ev_mon.valid && ev_mon.ready)
                check_event();
            if (key_mon.valid && key_mon.ready)
                predict_tick(key_mon.button0_level, key_mon.button1_level);
            mismatch_count     <= errors;
            events_outstanding <= expected_events.size();
        end
    end

endmodule

// ===== sim/tb_key_debounce_event_generator.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_key_debounce_event_generator: testbench for the key debounce block
// Drives scan ticks in bursts, programs the registers between phases over
// APB, stalls the event channel, and lets the checker score every event.
// ============================================================================
module tb_key_debounce_event_generator;
    import kdeg_pkg::*;

    // button patterns, {button1, button0}
    localparam logic [1:0] PAT_NONE = 2'b00;
    localparam logic [1:0] PAT_B0   = 2'b01;
    localparam logic [1:0] PAT_B1   = 2'b10;
    localparam logic [1:0] PAT_BOTH = 2'b11;

    // Tick enters a register, is scanned, lands in the bundle and drains one
    // event per cycle while the sink is ready; DRAIN_CYCLES covers the tail of a no-event tick.
    localparam int DRAIN_CYCLES = 16;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int mismatch_count;
    int events_outstanding;

    kdeg_key_if   key_ch ();
    kdeg_event_if ev_ch ();

    key_debounce_event_generator DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .key_in  (key_ch),
        .ev_out  (ev_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    kdeg_event_checker u_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .key_mon            (key_ch),
        .ev_mon             (ev_ch),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .pready             (pready),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .mismatch_count     (mismatch_count),
        .events_outstanding (events_outstanding)
    );

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Event sink: ready follows a mode picked every so often
    //   0: always ready, 1: coin flip, 2: alternating runs of random length,
    //   3: ready low whenever sink_cyc is a multiple of three
    // ------------------------------------------------------------------------
    int stall_mode = 0;
    int mode_left  = 0;
    int run_left   = 0;
    int sink_cyc   = 0;

    always @(posedge clk) begin
        if (!rst_n)
            ev_ch.ready <= 1'b0;
        else begin
            sink_cyc <= sink_cyc + 1;
            if (mode_left == 0) begin
                stall_mode <= $urandom_range(0, 3);
                mode_left  <= $urandom_range(30, 150);
            end else
                mode_left <= mode_left - 1;
            case (stall_mode)
                0: ev_ch.ready <= 1'b1;
                1: ev_ch.ready <= 1'($urandom_range(0, 1));
                2: begin
                    if (run_left == 0) begin
                        ev_ch.ready <= ~ev_ch.ready;
                        run_left    <= ev_ch.ready ? $urandom_range(1, 7)
                                                   : $urandom_range(1, 4);
                    end else
                        run_left <= run_left - 1;
                end
                default: ev_ch.ready <= (sink_cyc % 3 != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog. Slowest honest run: ~410 ticks, each after an idle gap,
    // passing the block with up to 4 events that may each wait out a sink
    // stall; 5 ms is far longer than such a run needs.
    // ------------------------------------------------------------------------
    initial begin
        #5_000_000;
        $display("tb_key_debounce_event_generator: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tick source
    // ------------------------------------------------------------------------
    int         burst_left = 0;
    logic [1:0] cur_pattern = PAT_NONE;

    // One tick; valid stays up across a burst, drops for a gap between bursts.
    task automatic send_tick(input logic [1:0] pat);
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 6)) @(posedge clk);
            // long bursts give stretches with no idling at all
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        key_ch.valid         <= 1'b1;
        key_ch.button0_level <= pat[0];
        key_ch.button1_level <= pat[1];
        @(posedge clk);
        while (!key_ch.ready)
            @(posedge clk);
        burst_left--;
        if (burst_left == 0)
            key_ch.valid <= 1'b0;
    endtask

    task automatic hold_buttons(input logic [1:0] pat, input int n);
        for (int i = 0; i < n; i++)
            send_tick(pat);
        cur_pattern = pat;
    endtask

    // Stop sending and wait until every predicted event has been seen.
    // The outstanding count is registered in the checker, hence the lead-in.
    task automatic settle_block();
        if (burst_left != 0) begin
            key_ch.valid <= 1'b0;
            burst_left = 0;
        end
        repeat (2) @(posedge clk);
        while (events_outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Register writes: setup cycle, then access cycle. psel stays up between
    // back-to-back writes and is dropped by the caller afterwards. Bits above
    // the field carry junk, the block must mask them.
    // ------------------------------------------------------------------------
    task automatic apb_write(input logic [2:0] idx, input logic [31:0] val,
                             input int width);
        logic [31:0] junk;
        junk     = $urandom();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= (junk << width) | val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
    endtask

    task automatic program_keys(input int f, input int l0, input int l1, input int l2,
                                input int r0, input int r1, input int r2);
        settle_block();
        apb_write(REG_FILTER_TIME,  32'(f),  7);
        apb_write(REG_LONG_KEY0,    32'(l0), 16);
        apb_write(REG_LONG_KEY1,    32'(l1), 16);
        apb_write(REG_LONG_COMBO,   32'(l2), 16);
        apb_write(REG_REPEAT_KEY0,  32'(r0), 8);
        apb_write(REG_REPEAT_KEY1,  32'(r1), 8);
        apb_write(REG_REPEAT_COMBO, 32'(r2), 8);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Random phase: mostly holds of one pattern long enough to reach long
    // press and repeat under small settings, with glitch ticks mixed in and
    // some short taps. A phase often carries on the pattern of the previous
    // one, so new limits land on a key that is already held.
    // ------------------------------------------------------------------------
    task automatic random_phase(input int n_items);
        int         sent;
        int         len;
        logic [1:0] pat;
        sent = 0;
        pat  = cur_pattern;
        while (sent < n_items) begin
            if (sent != 0 || $urandom_range(0, 1) == 0)
                pat = 2'($urandom_range(0, 3));
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3)
                                              : $urandom_range(4, 30);
            for (int i = 0; i < len && sent < n_items; i++) begin
                if ($urandom_range(0, 9) == 0)
                    send_tick(2'($urandom_range(0, 3)));
                else
                    send_tick(pat);
                sent++;
            end
        end
        cur_pattern = pat;
    endtask

    // pick a long time: mostly small, sometimes disabled or out of reach
    function automatic int pick_long();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 0;
        if (r == 9)
            return 65535;
        return $urandom_range(1, 12);
    endfunction

    function automatic int pick_repeat();
        if ($urandom_range(0, 9) == 0)
            return 255;
        return $urandom_range(0, 6);
    endfunction

    // ------------------------------------------------------------------------
    // Directed ticks, run with filter time zero: taps, a direct move from
    // the combination to key 0, fast alternation between single buttons
    // ------------------------------------------------------------------------
    logic [1:0] directed_ticks [25];

    initial begin
        directed_ticks = '{
            PAT_B0, PAT_B0, PAT_B0, PAT_B0, PAT_NONE, PAT_NONE,
            PAT_B1, PAT_B1, PAT_B1, PAT_B1, PAT_B1, PAT_NONE,
            PAT_BOTH, PAT_BOTH, PAT_BOTH, PAT_BOTH, PAT_B0,
            PAT_NONE, PAT_NONE,
            PAT_B1, PAT_B0, PAT_B1, PAT_B0,
            PAT_BOTH, PAT_BOTH
        };
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        rst_n                = 1'b0;
        key_ch.valid         = 1'b0;
        key_ch.button0_level = 1'b0;
        key_ch.button1_level = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: press key 0 through debounce, long press at 100,
        // repeats every 5, then release.
        hold_buttons(PAT_B0, 115);
        hold_buttons(PAT_NONE, 12);

        // Filter time zero, long press on the first settled tick for the
        // combination with repeat off; the write past the map is ignored.
        program_keys(0, 2, 3, 1, 1, 2, 0);
        apb_write(3'd7, $urandom(), 32);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        foreach (directed_ticks[i])
            send_tick(directed_ticks[i]);
        cur_pattern = PAT_BOTH;

        // Key 0 held, then its limits lowered under the hold count
        program_keys(1, 4, 3, 1, 3, 2, 0);
        hold_buttons(PAT_B0, 10);
        program_keys(1, 1, 3, 1, 1, 2, 0);
        hold_buttons(PAT_B0, 4);

        // Random phases; the first two at extreme settings
        for (int p = 0; p < 4; p++) begin
            if (p == 0)
                program_keys(1, 65535, 0, 3, 255, 3, 0);
            else if (p == 1)
                program_keys(4, 1, 1, 1, 1, 1, 1);
            else
                program_keys($urandom_range(0, 4), pick_long(), pick_long(),
                             pick_long(), pick_repeat(), pick_repeat(),
                             pick_repeat());
            random_phase(17);
        end

        // Widest filter: press needs the counter to climb to 254
        program_keys(127, 1, 100, 100, 0, 6, 5);
        hold_buttons(PAT_B0, 140);
        // Filter dropped below the count while held, long repeat period
        program_keys(1, 1, 100, 100, 25, 6, 5);
        hold_buttons(PAT_B0, 30);
        hold_buttons(PAT_NONE, 6);

        settle_block();
        if (mismatch_count == 0 && events_outstanding == 0)
            $display("tb_key_debounce_event_generator: PASS");
        else
            $display("tb_key_debounce_event_generator: FAIL");
        $finish;
    end

endmodule
